[sv/ctf_pkg.sv]
// Shared types and constants for the CRC-16 / COBS telemetry framer.
// Holds the frame layout types and the parallel CRC-16 column table.
// No dependencies.
`default_nettype none

package ctf_pkg;

    // Frame layout.
    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned MSG_W     = NUM_WORDS * WORD_W;
    localparam int unsigned RAW_LEN   = 14;
    localparam int unsigned ENC_LEN   = 15;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef logic [RAW_LEN-1:0][7:0] t_raw;
    typedef logic [ENC_LEN-1:0][7:0] t_enc;
    typedef logic [MSG_W-1:0][15:0]  t_crc_cols;

    // The CRC is linear in the message bits, so each message bit contributes a
    // fixed 16-bit column. Bit MSG_W-1 is the first bit sent (MSB of the first
    // byte). The table is built once at elaboration.
    function automatic t_crc_cols crc_columns();
        t_crc_cols   cols;
        logic [15:0] crc;
        logic        fb;
        for (int n = 0; n < MSG_W; n++) begin
            crc = '0;
            for (int t = 0; t < MSG_W; t++) begin
                fb  = crc[15] ^ ((MSG_W - 1 - t) == n);
                crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
            cols[n] = crc;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_columns();

endpackage

`default_nettype wire

[sv/ctf_cobs_enc.sv]
// COBS encoder for one fixed 14-byte raw frame, producing 15 encoded bytes.
// Purely combinational; depends on ctf_pkg for the frame types.
`default_nettype none

module ctf_cobs_enc (
    input  ctf_pkg::t_raw i_raw,
    output ctf_pkg::t_enc o_enc
);
    import ctf_pkg::*;

    logic [RAW_LEN-1:0] zero_flag;

    // Mark the zero bytes of the raw frame.
    always_comb begin
        for (int i = 0; i < RAW_LEN; i++) begin
            zero_flag[i] = (i_raw[i] == 8'h00);
        end
    end

    // Distance from position p to the next zero byte at or after p, plus one.
    // The last raw byte is always zero, so a zero is always found.
    function automatic logic [3:0] code_at(logic [RAW_LEN-1:0] z, int p);
        logic [3:0] d;
        d = 4'(ENC_LEN - p);
        for (int q = RAW_LEN - 1; q >= 0; q--) begin
            if (q >= p && z[q]) begin
                d = 4'(q - p + 1);
            end
        end
        return d;
    endfunction

    // Encoded byte p carries raw byte p-1, or a block code where that byte
    // was zero. The leading byte is always a code.
    always_comb begin
        o_enc[0] = {4'b0000, code_at(zero_flag, 0)};
        for (int p = 1; p < ENC_LEN; p++) begin
            if (zero_flag[p-1]) begin
                o_enc[p] = {4'b0000, code_at(zero_flag, p)};
            end else begin
                o_enc[p] = i_raw[p-1];
            end
        end
    end

endmodule

`default_nettype wire

[sv/crc16_cobs_telemetry_framer.sv]
// Top level of the CRC-16 / COBS telemetry framer.
// Depends on ctf_pkg and ctf_cobs_enc.
//
// Each input request carries five 16-bit telemetry words. The block builds a
// 14-byte frame (the words high byte first, CRC-16 XMODEM over those ten
// bytes, a wrapping 8-bit frame counter, a zero byte), COBS encodes it to 15
// bytes and appends a zero delimiter, which is flagged by m_axis_tlast. Every
// frame is exactly 16 output bytes, one byte per cycle while the sink is ready,
// so the byte serializer sets the rate at which new frames are taken. A frame
// passes an input register and a raw-frame register before it is loaded into
// the serializer, so new frames are taken in while one is still being sent,
// and the next frame loads as the previous delimiter leaves.
`default_nettype none

module crc16_cobs_telemetry_framer (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // Input stream.
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, from bit 0 up: word_state, word_two, word_line_rms, word_four,
    // word_drive.
    input  wire  [ctf_pkg::MSG_W-1:0]  s_axis_tdata,
    // Output stream.
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // tdata, from bit 0 up: out_byte.
    output logic [7:0]                 m_axis_tdata,
    // tlast: frame_end.
    output logic                       m_axis_tlast
);
    import ctf_pkg::*;

    localparam logic [3:0] LAST_IDX = 4'(ENC_LEN);

    logic [7:0]        r_cnt;
    logic              r_s1_vld;
    logic [MSG_W-1:0]  r_s1_msg;
    logic [7:0]        r_s1_cnt;
    logic              r_s2_vld;
    t_raw              r_s2_raw;
    logic              r_busy;
    logic [3:0]        r_idx;
    logic [ENC_LEN*8-1:0] r_shift;

    logic              in_acc;
    logic              out_acc;
    logic              out_last;
    logic              s1_go;
    logic              s2_go;
    logic [MSG_W-1:0]  msg;
    logic [15:0]       crc;
    t_raw              n_raw;
    t_enc              enc;

    // Stage handshakes: each register moves on when the next one is free.
    assign out_acc       = r_busy && m_axis_tready;
    assign out_last      = out_acc && (r_idx == LAST_IDX);
    assign s2_go         = r_s2_vld && (!r_busy || out_last);
    assign s1_go         = r_s1_vld && (!r_s2_vld || s2_go);
    assign s_axis_tready = !r_s1_vld || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Message bits in send order, first word's MSB on top.
    assign msg = {r_s1_msg[15:0], r_s1_msg[31:16], r_s1_msg[47:32],
                  r_s1_msg[63:48], r_s1_msg[79:64]};

    // Parallel CRC-16: XOR of the columns of the set message bits.
    always_comb begin
        crc = '0;
        for (int n = 0; n < MSG_W; n++) begin
            if (msg[n]) begin
                crc = crc ^ CRC_COLS[n];
            end
        end
    end

    // Raw frame assembly.
    always_comb begin
        for (int k = 0; k < 2 * NUM_WORDS; k++) begin
            n_raw[k] = msg[MSG_W-1-8*k -: 8];
        end
        n_raw[10] = crc[15:8];
        n_raw[11] = crc[7:0];
        n_raw[12] = r_s1_cnt;
        n_raw[13] = 8'h00;
    end

    ctf_cobs_enc u_cobs_enc (
        .i_raw (r_s2_raw),
        .o_enc (enc)
    );

    // Control registers: frame counter, stage valids, serializer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_busy   <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (in_acc) begin
                r_cnt <= r_cnt + 8'd1;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_s2_vld <= 1'b1;
            end else if (s2_go) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_go) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_acc) begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == LAST_IDX) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Payload registers. The shift register fills with zeros from the top, so
    // the byte after the fifteen encoded ones is the delimiter.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_msg <= s_axis_tdata;
            r_s1_cnt <= r_cnt;
        end
        if (s1_go) begin
            r_s2_raw <= n_raw;
        end
        if (s2_go) begin
            r_shift <= enc;
        end else if (out_acc) begin
            r_shift <= {8'h00, r_shift[ENC_LEN*8-1:8]};
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = r_shift[7:0];
    assign m_axis_tlast  = (r_idx == LAST_IDX);

endmodule

`default_nettype wire

[sv/ctf_checker.sv]
// Port-level checker for the telemetry framer output stream, bound to the top.
// Depends on ctf_pkg for the input width.
`default_nettype none

module ctf_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       s_axis_tvalid,
    input wire                       s_axis_tready,
    input wire [ctf_pkg::MSG_W-1:0]  s_axis_tdata,
    input wire                       m_axis_tvalid,
    input wire                       m_axis_tready,
    input wire [7:0]                 m_axis_tdata,
    input wire                       m_axis_tlast
);
    import ctf_pkg::*;

    logic [3:0] r_beat;
    logic       in_seen;

    assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1 || 1'b1);

    // Count output bytes within the current frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_beat <= m_axis_tlast ? 4'd0 : r_beat + 4'd1;
        end
    end

    // The delimiter is always the sixteenth byte of a frame.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> r_beat == 4'(ENC_LEN))
        else $error("frame delimiter not on the sixteenth byte");

    // The delimiter is zero and no encoded byte is.
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
        else $error("frame delimiter is not zero");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata != 8'h00)
        else $error("zero byte inside an encoded frame");

    // A stalled output request holds its byte and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output request changed");

    // No frame can leave the block without one having been taken in.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_seen && !$past(m_axis_tvalid) && !$past(in_seen) && $past(i_rst_n)
            && !$past(s_axis_tvalid) && !$past(m_axis_tvalid, 2)
            && !$past(s_axis_tvalid, 2) && $past(i_rst_n, 2)
            && !$past(s_axis_tvalid, 3) && $past(i_rst_n, 3)
            && !$past(m_axis_tvalid, 3)
        |-> !m_axis_tvalid)
        else $error("output request without a preceding input request");

endmodule

bind crc16_cobs_telemetry_framer ctf_checker u_ctf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
